### design/usss_pkg.sv
// Package for the unipolar stepper sequencer: request codes, word structs,
// coil pattern tables and the cycle-count reciprocal constants.
// No dependencies.
package usss_pkg;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2
    } t_req;

    localparam int CNT_W     = 17;
    localparam int ANGLE_W   = 16;
    localparam int PERIOD_W  = 8;
    localparam int RECIP_W   = 23;
    // floor(a*64/45) == (a * ceil(2^28/45)) >> 22, exact for 16-bit a
    localparam logic [RECIP_W-1:0] CNT_RECIP = 23'd5965233;
    localparam int CNT_SHIFT = 22;

    localparam logic [3:0] FULL_LEN = 4'd4;
    localparam logic [3:0] HALF_LEN = 4'd8;

    // bit 0 blue, bit 1 pink, bit 2 yellow, bit 3 orange
    localparam logic [3:0] FULL_TAB [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
    localparam logic [3:0] HALF_TAB [8] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                            4'h4, 4'hC, 4'h8, 4'h9};

    typedef struct packed {
        logic [1:0]          req_type;
        logic                step_mode;
        logic                direction;
        logic [PERIOD_W-1:0] step_period_ms;
        logic [ANGLE_W-1:0]  angle_degrees;
    } t_item;

    typedef struct packed {
        logic [3:0] coils;
        logic       busy;
        logic       done;
    } t_result;

    function automatic logic [3:0] pattern_at(input logic half, input logic rev,
                                              input logic [2:0] ph);
        logic [2:0] k;
        logic [1:0] kf;
        logic [3:0] pat;
        if (half) begin
            k   = rev ? (3'd7 - ph) : ph;
            pat = HALF_TAB[k];
        end else begin
            kf  = rev ? (2'd3 - ph[1:0]) : ph[1:0];
            pat = FULL_TAB[kf];
        end
        return pat;
    endfunction

endpackage

### design/usss_cnt.sv
// Angle to sequence count: floor(angle*64/45) by reciprocal multiply.
// Depends on usss_pkg.
module usss_cnt (
    input  logic [usss_pkg::ANGLE_W-1:0] i_angle,
    output logic [usss_pkg::CNT_W-1:0]   o_count
);
    import usss_pkg::*;

    logic [ANGLE_W+RECIP_W-1:0] w_prod;

    assign w_prod  = ANGLE_W'(i_angle) * (ANGLE_W + RECIP_W)'(CNT_RECIP);
    assign o_count = w_prod[CNT_SHIFT +: CNT_W];

endmodule

### design/usss_core.sv
// Sequencer state: phase, tick and cycle counters, mode and coil levels.
// Depends on usss_pkg and usss_cnt.
module usss_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  usss_pkg::t_item   i_item,
    output usss_pkg::t_result o_result
);
    import usss_pkg::*;

    logic [2:0]          r_phase,   n_phase;
    logic [CNT_W-1:0]    r_cycles,  n_cycles;
    logic [PERIOD_W-1:0] r_tick,    n_tick;
    logic [PERIOD_W-1:0] r_period,  n_period;
    logic                r_half,    n_half;
    logic                r_rev,     n_rev;
    logic                r_running, n_running;
    logic [3:0]          r_coils,   n_coils;
    logic                n_done;

    logic [CNT_W-1:0]    w_count;
    logic [CNT_W-1:0]    w_cycles_dec;
    logic [PERIOD_W:0]   w_tick_inc;
    logic [3:0]          w_phase_inc;
    logic [3:0]          w_len;

    usss_cnt u_cnt (
        .i_angle (i_item.angle_degrees),
        .o_count (w_count)
    );

    assign w_tick_inc   = {1'b0, r_tick} + 1'b1;
    assign w_phase_inc  = {1'b0, r_phase} + 4'd1;
    assign w_len        = r_half ? HALF_LEN : FULL_LEN;
    assign w_cycles_dec = (r_cycles != '0) ? (r_cycles - 1'b1) : r_cycles;

    always_comb begin
        n_phase   = r_phase;
        n_cycles  = r_cycles;
        n_tick    = r_tick;
        n_period  = r_period;
        n_half    = r_half;
        n_rev     = r_rev;
        n_running = r_running;
        n_coils   = r_coils;
        n_done    = 1'b0;
        if (i_fire) begin
            case (t_req'(i_item.req_type))
                REQ_START: begin
                    n_half   = i_item.step_mode;
                    n_rev    = i_item.direction;
                    n_period = i_item.step_period_ms;
                    n_tick   = '0;
                    n_phase  = '0;
                    n_cycles = w_count;
                    if (w_count != '0) begin
                        n_running = 1'b1;
                        n_coils   = pattern_at(i_item.step_mode, i_item.direction, 3'd0);
                    end else begin
                        n_running = 1'b0;
                    end
                end
                REQ_STOP: begin
                    n_coils   = '0;
                    n_running = 1'b0;
                    n_cycles  = '0;
                    n_tick    = '0;
                    n_phase   = '0;
                end
                REQ_TICK: begin
                    if (r_running) begin
                        if (w_tick_inc >= {1'b0, r_period}) begin
                            n_tick = '0;
                            if (w_phase_inc >= w_len) begin
                                n_cycles = w_cycles_dec;
                                if (w_cycles_dec == '0) begin
                                    n_running = 1'b0;
                                    n_done    = 1'b1;
                                end else begin
                                    n_phase = '0;
                                    n_coils = pattern_at(r_half, r_rev, 3'd0);
                                end
                            end else begin
                                n_phase = w_phase_inc[2:0];
                                n_coils = pattern_at(r_half, r_rev, w_phase_inc[2:0]);
                            end
                        end else begin
                            n_tick = w_tick_inc[PERIOD_W-1:0];
                        end
                    end
                end
                default: begin
                    // unused code: report state unchanged
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_cycles  <= '0;
            r_tick    <= '0;
            r_period  <= '0;
            r_half    <= 1'b0;
            r_rev     <= 1'b0;
            r_running <= 1'b0;
            r_coils   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_cycles  <= n_cycles;
            r_tick    <= n_tick;
            r_period  <= n_period;
            r_half    <= n_half;
            r_rev     <= n_rev;
            r_running <= n_running;
            r_coils   <= n_coils;
        end
    end

    assign o_result = '{coils: n_coils, busy: n_running, done: n_done};

    a_run_has_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_cycles != '0))
        else $error("running with no sequences left");

    a_full_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_half |-> (r_phase <= 3'd3))
        else $error("full-step phase out of range");

    a_done_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.done) |-> (!o_result.busy && r_running &&
                                       i_item.req_type == REQ_TICK))
        else $error("move_done outside a finishing tick");

endmodule

### design/unipolar_stepper_sequencer_unit.sv
// Top level of the unipolar stepper sequencer: input register, output register
// and handshake. Depends on usss_pkg and usss_core (which uses usss_cnt).
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------
//  in      | to block  | i_in_valid / o_in_ready  | req_type, step_mode, direction,
//          |           |                          | step_period_ms, angle_degrees
//  out     | from block| o_out_valid / i_out_ready| coil_blue/pink/yellow/orange,
//          |           |                          | busy_res, move_done
//
// One word per cycle sustained while the output is not stalled; a request is first held
// in the input register, then the state update writes its result word into the result
// register once the output can advance.
// The per-word path is the 16x23 reciprocal multiply for the cycle count plus
// the counter and pattern selection.
// Reset (i_rst_n low, synchronous) stops the sequencer: coil state off, idle, both
// registers empty; the coil outputs keep the last result word until it is replaced.
// A stalled output holds its word; the input register keeps accepting while
// it is empty or while its word moves into the result register.
module unipolar_stepper_sequencer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_req_type,
    input  logic       i_step_mode,
    input  logic       i_direction,
    input  logic [7:0] i_step_period_ms,
    input  logic [15:0] i_angle_degrees,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_coil_blue,
    output logic       o_coil_pink,
    output logic       o_coil_yellow,
    output logic       o_coil_orange,
    output logic       o_busy_res,
    output logic       o_move_done
);
    import usss_pkg::*;

    logic    r_in_vld;
    t_item   r_in;
    logic    r_out_vld;
    t_result r_out;
    t_result w_result;
    logic    w_adv;
    logic    w_fire;

    // advance the pipe when the result register is empty or being drained
    assign w_adv      = !r_out_vld || i_out_ready;
    assign w_fire     = r_in_vld && w_adv;
    assign o_in_ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    // capture the request word
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= '{req_type:       i_req_type,
                      step_mode:      i_step_mode,
                      direction:      i_direction,
                      step_period_ms: i_step_period_ms,
                      angle_degrees:  i_angle_degrees};
        end
    end

    usss_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_fire;
        end
    end

    // hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_coil_blue   = r_out.coils[0];
    assign o_coil_pink   = r_out.coils[1];
    assign o_coil_yellow = r_out.coils[2];
    assign o_coil_orange = r_out.coils[3];
    assign o_busy_res    = r_out.busy;
    assign o_move_done   = r_out.done;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |-> !w_fire)
        else $error("result word overwritten while stalled");

    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_vld)
        else $error("processed word lost before output");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> o_in_ready)
        else $error("input blocked with empty input register");

endmodule
